// File: rtl/rbr_pkg.sv
// rbr_pkg: shared types, codes and saturation helpers for the ReLU bound relaxation block.
// No dependencies; every other rtl file but rbr_queue uses it by scoped names.

package rbr_pkg;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_PATH_ON = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_PATH_ON = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CLS_INACTIVE = 2'd0,
		CLS_ACTIVE   = 2'd1,
		CLS_UNSTABLE = 2'd2
	} class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MB,
		ST_ML,
		ST_MU,
		ST_MLB,
		ST_MUB,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic lower_on;
		logic upper_on;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] bound_lo;
		logic signed [31:0] bound_hi;
		logic signed [31:0] coef_lower;
		logic signed [31:0] coef_upper;
		logic               row_last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_coef_lower;
		logic signed [31:0] new_coef_upper;
		logic signed [47:0] bias_sum_lower;
		logic signed [47:0] bias_sum_upper;
		logic               sums_valid;
		logic [1:0]         neuron_class;
	} out_item_t;

	// Classified neuron handed from front to back
	typedef struct packed {
		class_t             cls;
		logic               lo_one;     // lower slope is one
		logic               row_last;
		logic [31:0]        upper_mag;  // u, dividend seed
		logic [31:0]        den;        // u - l, valid when unstable
		logic [31:0]        neg_l;      // -l when unstable, else zero
		logic signed [31:0] coef_lower;
		logic signed [31:0] coef_upper;
	} work_t;

	function automatic logic signed [31:0] sat_s32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat_s48(input logic signed [65:0] v);
		logic signed [47:0] r;
		if (v > 66'sd140737488355327)
			r = 48'sh7FFF_FFFF_FFFF;
		else if (v < -66'sd140737488355328)
			r = 48'sh8000_0000_0000;
		else
			r = v[47:0];
		return r;
	endfunction

endpackage

// File: rtl/relu_bound_relaxation_backward.sv
// relu_bound_relaxation_backward: top level of the ReLU linear relaxation backward step.
// Depends on rbr_pkg, rbr_front, rbr_queue and rbr_back.
//
//  channel   handshake             payload                    direction
//  --------  --------------------  -------------------------  ---------
//  item      push / full           rbr_pkg::in_item_t item    in
//  result    pop / empty           rbr_pkg::out_item_t result out
//  config    cfg_valid / cfg_ready cfg_index, cfg_data        in
//
// In the back end an unstable neuron passes the serial divider (one quotient bit per
// cycle), then makes five passes through the single shared multiplier and a combine
// step; a stable neuron skips the divider and goes straight to the multiplier passes.
// The front classifies in the accept cycle; a four-entry work queue decouples it,
// and a two-entry result queue keeps the back end going while results wait.
// Reset is asynchronous and active low; it restores both path enables and clears
// the row sums. Config writes are always accepted (cfg_ready is always high).

module relu_bound_relaxation_backward #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned WQ_DEPTH  = 4,
	parameter int unsigned RQ_DEPTH  = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input side
	input  logic                               push,
	output logic                               full,
	input  rbr_pkg::in_item_t                  item,
	// result side
	output logic                               empty,
	input  logic                               pop,
	output rbr_pkg::out_item_t                 result,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rbr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rbr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned WORK_W = $bits(rbr_pkg::work_t);
	localparam int unsigned OUT_W  = $bits(rbr_pkg::out_item_t);

	rbr_pkg::cfg_t      cfg_q;
	rbr_pkg::work_t     front_work;
	rbr_pkg::work_t     back_work;
	rbr_pkg::out_item_t back_result;

	logic              wq_push, wq_full, wq_pop, wq_empty;
	logic [WORK_W-1:0] wq_dout;
	logic              rq_push, rq_full;
	logic [OUT_W-1:0]  rq_dout;

	// Configuration registers: take only bit 0, drop writes to unknown indexes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_on <= 1'b1;
			cfg_q.upper_on <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rbr_pkg::CFG_LOWER_PATH_ON: cfg_q.lower_on <= cfg_data[0];
				rbr_pkg::CFG_UPPER_PATH_ON: cfg_q.upper_on <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front: classify and hand off to the work queue
	rbr_front u_front (
		.item    (item),
		.push    (push),
		.full    (full),
		.wq_push (wq_push),
		.wq_full (wq_full),
		.work    (front_work)
	);

	rbr_queue #(
		.W     (WORK_W),
		.DEPTH (WQ_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.full   (wq_full),
		.din    (front_work),
		.pop    (wq_pop),
		.empty  (wq_empty),
		.dout   (wq_dout)
	);

	assign back_work = rbr_pkg::work_t'(wq_dout);

	// Back: divide, multiply, accumulate row bias sums
	rbr_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.wq_empty (wq_empty),
		.wq_pop   (wq_pop),
		.work     (back_work),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.result   (back_result)
	);

	// Result queue: hold finished transactions until popped
	rbr_queue #(
		.W     (OUT_W),
		.DEPTH (RQ_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.full   (rq_full),
		.din    (back_result),
		.pop    (pop),
		.empty  (empty),
		.dout   (rq_dout)
	);

	assign result = rbr_pkg::out_item_t'(rq_dout);

endmodule

// File: rtl/rbr_queue.sv
// rbr_queue: small register queue with push/full and pop/empty sides.
// Depends on nothing; used between front and back and at the result side.

module rbr_queue #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] dout
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue push lost");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("queue pop lost");

endmodule

// File: rtl/rbr_front.sv
// rbr_front: classifies each accepted neuron and prepares the divider operands.
// Depends on rbr_pkg; feeds the work queue.

module rbr_front (
	input  rbr_pkg::in_item_t item,
	input  logic              push,
	output logic              full,
	output logic              wq_push,
	input  logic              wq_full,
	output rbr_pkg::work_t    work
);

	logic signed [32:0] u_ext;
	logic signed [32:0] l_ext;
	logic signed [32:0] diff;
	logic signed [32:0] lsum;
	logic signed [32:0] neg_l;
	rbr_pkg::class_t    cls;

	assign u_ext = {item.bound_hi[31], item.bound_hi};
	assign l_ext = {item.bound_lo[31], item.bound_lo};
	assign diff  = u_ext - l_ext;
	assign lsum  = u_ext + l_ext;   // u > -l  <=>  u + l > 0
	assign neg_l = -l_ext;

	always_comb begin
		if (item.bound_hi <= 32'sd0)
			cls = rbr_pkg::CLS_INACTIVE;
		else if (item.bound_lo >= 32'sd0)
			cls = rbr_pkg::CLS_ACTIVE;
		else
			cls = rbr_pkg::CLS_UNSTABLE;
	end

	always_comb begin
		work.cls        = cls;
		work.row_last   = item.row_last;
		work.upper_mag  = item.bound_hi;
		work.den        = diff[31:0];
		work.coef_lower = item.coef_lower;
		work.coef_upper = item.coef_upper;
		case (cls)
			rbr_pkg::CLS_ACTIVE: begin
				work.lo_one = 1'b1;
				work.neg_l  = '0;
			end
			rbr_pkg::CLS_UNSTABLE: begin
				work.lo_one = (lsum > 33'sd0);
				work.neg_l  = neg_l[31:0];
			end
			default: begin
				work.lo_one = 1'b0;
				work.neg_l  = '0;
			end
		endcase
	end

	assign full    = wq_full;
	assign wq_push = push;

endmodule

// File: rtl/rbr_back.sv
// rbr_back: sequencer with a bit-serial divider and one shared multiplier that
// computes slopes, coefficients and row bias sums. Depends on rbr_pkg.

module rbr_back #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rbr_pkg::cfg_t      cfg,
	input  logic               wq_empty,
	output logic               wq_pop,
	input  rbr_pkg::work_t     work,
	input  logic               rq_full,
	output logic               rq_push,
	output rbr_pkg::out_item_t result
);

	localparam int unsigned CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	rbr_pkg::seq_state_t state_q, state_d;
	rbr_pkg::work_t      w_q;

	logic [31:0]        rem_q;
	logic [FRAC_BITS:0] s_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [32:0] upb_q;
	logic signed [32:0] lpart_q;
	logic signed [32:0] upart_q;
	logic signed [47:0] tl_q;
	logic signed [65:0] prod_q;
	logic signed [47:0] acc_l_q;
	logic signed [47:0] acc_u_q;

	logic [32:0]        r2;
	logic               qbit;
	logic [31:0]        rem_nx;
	logic signed [32:0] s_ext;
	logic signed [32:0] negl_ext;
	logic signed [32:0] p_l, n_l, p_u, n_u;
	logic signed [32:0] mul_a, mul_b;
	logic               mul_en;
	logic signed [65:0] prod_sh;
	logic signed [47:0] tu;
	logic signed [48:0] sum_l, sum_u;
	logic signed [47:0] sl, su;
	logic signed [33:0] cl_sum, cu_sum;
	logic               fin_fire;

	// Restoring division, one quotient bit per cycle
	assign r2     = {rem_q, 1'b0};
	assign qbit   = (r2 >= {1'b0, w_q.den});
	assign rem_nx = qbit ? 32'(r2 - {1'b0, w_q.den}) : r2[31:0];

	assign s_ext    = {{(32 - FRAC_BITS){1'b0}}, s_q};
	assign negl_ext = {1'b0, w_q.neg_l};

	// Split coefficients; a disabled path contributes nothing
	always_comb begin
		p_l = '0; n_l = '0; p_u = '0; n_u = '0;
		if (cfg.lower_on) begin
			if (w_q.coef_lower > 32'sd0) p_l = {w_q.coef_lower[31], w_q.coef_lower};
			if (w_q.coef_lower < 32'sd0) n_l = {w_q.coef_lower[31], w_q.coef_lower};
		end
		if (cfg.upper_on) begin
			if (w_q.coef_upper > 32'sd0) p_u = {w_q.coef_upper[31], w_q.coef_upper};
			if (w_q.coef_upper < 32'sd0) n_u = {w_q.coef_upper[31], w_q.coef_upper};
		end
	end

	assign prod_sh = prod_q >>> FRAC_BITS;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbr_pkg::ST_IDLE: begin
				if (!wq_empty)
					state_d = (work.cls == rbr_pkg::CLS_UNSTABLE) ? rbr_pkg::ST_DIV
					                                              : rbr_pkg::ST_MB;
			end
			rbr_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = rbr_pkg::ST_MB;
			end
			rbr_pkg::ST_MB:  state_d = rbr_pkg::ST_ML;
			rbr_pkg::ST_ML:  state_d = rbr_pkg::ST_MU;
			rbr_pkg::ST_MU:  state_d = rbr_pkg::ST_MLB;
			rbr_pkg::ST_MLB: state_d = rbr_pkg::ST_MUB;
			rbr_pkg::ST_MUB: state_d = rbr_pkg::ST_FIN;
			rbr_pkg::ST_FIN: begin
				if (!rq_full) state_d = rbr_pkg::ST_IDLE;
			end
			default: state_d = rbr_pkg::ST_IDLE;
		endcase
	end

	// Outputs and multiplier operand selection
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_en  = 1'b0;
		wq_pop  = 1'b0;
		rq_push = 1'b0;
		case (state_q)
			rbr_pkg::ST_IDLE: wq_pop = !wq_empty;
			rbr_pkg::ST_MB: begin
				mul_a = negl_ext; mul_b = s_ext; mul_en = 1'b1;
			end
			rbr_pkg::ST_ML: begin
				mul_a = n_l; mul_b = s_ext; mul_en = 1'b1;
			end
			rbr_pkg::ST_MU: begin
				mul_a = p_u; mul_b = s_ext; mul_en = 1'b1;
			end
			rbr_pkg::ST_MLB: begin
				mul_a = n_l; mul_b = upb_q; mul_en = 1'b1;
			end
			rbr_pkg::ST_MUB: begin
				mul_a = p_u; mul_b = upb_q; mul_en = 1'b1;
			end
			rbr_pkg::ST_FIN: rq_push = 1'b1;
			default: ;
		endcase
	end

	assign fin_fire = rq_push && !rq_full;

	// Final combine: upper bias term, saturated sums, coefficients
	assign tu     = rbr_pkg::sat_s48(prod_sh);
	assign sum_l  = {acc_l_q[47], acc_l_q} + {tl_q[47], tl_q};
	assign sum_u  = {acc_u_q[47], acc_u_q} + {tu[47], tu};
	assign sl     = rbr_pkg::sat_s48({{17{sum_l[48]}}, sum_l});
	assign su     = rbr_pkg::sat_s48({{17{sum_u[48]}}, sum_u});
	assign cl_sum = {lpart_q[32], lpart_q} + (w_q.lo_one ? {p_l[32], p_l} : 34'sd0);
	assign cu_sum = {upart_q[32], upart_q} + (w_q.lo_one ? {n_u[32], n_u} : 34'sd0);

	always_comb begin
		result.new_coef_lower = rbr_pkg::sat_s32(cl_sum);
		result.new_coef_upper = rbr_pkg::sat_s32(cu_sum);
		result.bias_sum_lower = w_q.row_last ? sl : '0;
		result.bias_sum_upper = w_q.row_last ? su : '0;
		result.sums_valid     = w_q.row_last;
		result.neuron_class   = w_q.cls;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			rbr_pkg::ST_IDLE: begin
				if (!wq_empty) begin
					w_q   <= work;
					rem_q <= work.upper_mag;
					s_q   <= (work.cls == rbr_pkg::CLS_ACTIVE) ? ONE : '0;
					cnt_q <= CNT_W'(FRAC_BITS - 1);
				end
			end
			rbr_pkg::ST_DIV: begin
				rem_q <= rem_nx;
				s_q   <= {s_q[FRAC_BITS-1:0], qbit};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			rbr_pkg::ST_ML:  upb_q   <= prod_sh[32:0];
			rbr_pkg::ST_MU:  lpart_q <= prod_sh[32:0];
			rbr_pkg::ST_MLB: upart_q <= prod_sh[32:0];
			rbr_pkg::ST_MUB: tl_q    <= rbr_pkg::sat_s48(prod_sh);
			default: ;
		endcase
	end

	// Control state and row accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbr_pkg::ST_IDLE;
			acc_l_q <= '0;
			acc_u_q <= '0;
		end else begin
			state_q <= state_d;
			if (fin_fire) begin
				acc_l_q <= w_q.row_last ? '0 : sl;
				acc_u_q <= w_q.row_last ? '0 : su;
			end
		end
	end

	a_div_unstable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbr_pkg::ST_DIV |-> w_q.cls == rbr_pkg::CLS_UNSTABLE)
		else $error("divider running on a stable neuron");

	a_slope_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbr_pkg::ST_MB && w_q.cls == rbr_pkg::CLS_UNSTABLE |-> !s_q[FRAC_BITS])
		else $error("secant slope reached one");

	a_stable_no_bias: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbr_pkg::ST_MU && w_q.cls != rbr_pkg::CLS_UNSTABLE |-> upb_q == '0)
		else $error("stable neuron has secant bias");

	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && w_q.row_last |=> acc_l_q == '0 && acc_u_q == '0)
		else $error("row sums not restarted");

endmodule
